/* sv/sist_pkg.sv */
// Package for the small integer set table: sizes, operation codes and the
// structs passed between the top level and the search cells.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package sist_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef logic [1:0]             t_op;
    typedef logic [VALUE_WIDTH-1:0] t_value;
    typedef logic [IDX_W-1:0]       t_idx;
    typedef logic [CNT_W-1:0]       t_count;

    localparam t_op OP_INSERT = 2'd1;
    localparam t_op OP_REMOVE = 2'd2;

    typedef struct packed {
        logic   valid;
        logic   hit;
        t_idx   slot;
        t_value last;
    } t_token;

    typedef struct packed {
        logic   en;
        t_idx   idx;
        t_value data;
    } t_wr;

    function automatic t_value f_key(input logic [31:0] v);
        logic [63:0] ext;
        ext = {{32{v[31]}}, v};
        return ext[VALUE_WIDTH-1:0];
    endfunction

endpackage

/* sv/sist_cell.sv */
// One slot of the set table: holds one entry and passes the search token on
// to the next cell each cycle. Depends on sist_pkg.
`timescale 1ns / 1ps

module sist_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sist_pkg::t_idx   i_index,
    input  sist_pkg::t_value i_key,
    input  sist_pkg::t_count i_count,
    input  sist_pkg::t_wr    i_wr,
    input  sist_pkg::t_token i_tok,
    output sist_pkg::t_token o_tok
);

    sist_pkg::t_value r_entry;
    sist_pkg::t_token r_tok;
    sist_pkg::t_token n_tok;
    logic             w_in_use;
    logic             w_is_last;
    sist_pkg::t_count w_pos;

    assign w_pos     = sist_pkg::CNT_W'(i_index);
    assign w_in_use  = w_pos < i_count;
    assign w_is_last = (w_pos + sist_pkg::CNT_W'(1)) == i_count;

    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && !i_tok.hit && w_in_use && (r_entry == i_key)) begin
            n_tok.hit  = 1'b1;
            n_tok.slot = i_index;
        end
        if (w_is_last) begin
            n_tok.last = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.hit  <= n_tok.hit;
        r_tok.slot <= n_tok.slot;
        r_tok.last <= n_tok.last;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.idx == i_index)) begin
            r_entry <= i_wr.data;
        end
    end

    assign o_tok = r_tok;

endmodule

/* sv/small_integer_set_table_top.sv */
// Top level of the small integer set table: request control, count, the row
// of search cells and the result register. Depends on sist_pkg and sist_cell.
//
//   Channel  Direction  Contents (lowest bit first)
//   s_axis   in         op[1:0], value[33:2], zero pad to 40 bits
//   m_axis   out        found[0], member_count[7:1], full_reject[8], zero pad
//
// A request passes from acceptance through the launch register, the register
// of each cell of the search row, the capture of the token at the end of the
// row, and the commit state, where its result is registered.
// The next request is accepted in the cycle after the commit.
// Reset clears the count and the control state; the entries are not cleared.
// A result may wait in the output register while the next request searches;
// that request then holds in its commit cycle until the result is taken.
`timescale 1ns / 1ps

module small_integer_set_table_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // op[1:0], value[33:2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // found[0], member_count[7:1], full_reject[8]
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    t_state           r_state;
    t_state           n_state;
    sist_pkg::t_op    r_op;
    sist_pkg::t_value r_key;
    sist_pkg::t_count r_count;
    sist_pkg::t_count n_count;
    logic             r_launch;
    logic             r_hit;
    sist_pkg::t_idx   r_slot;
    sist_pkg::t_value r_last;
    logic             r_out_valid;
    logic [15:0]      r_out_data;

    logic             w_accept;
    logic             w_commit;
    logic             w_full;
    logic             w_is_ins;
    logic             w_ins_do;
    logic             w_rem_do;
    logic             w_reject;
    sist_pkg::t_wr    w_wr;
    sist_pkg::t_token w_tok [sist_pkg::CAPACITY+1];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_commit      = (r_state == S_COMMIT) && (!r_out_valid || m_axis_tready);

    assign w_tok[0].valid = r_launch;
    assign w_tok[0].hit   = 1'b0;
    assign w_tok[0].slot  = '0;
    assign w_tok[0].last  = '0;

    genvar g;
    generate
        for (g = 0; g < sist_pkg::CAPACITY; g++) begin : g_cell
            sist_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_index (sist_pkg::IDX_W'(g)),
                .i_key   (r_key),
                .i_count (r_count),
                .i_wr    (w_wr),
                .i_tok   (w_tok[g]),
                .o_tok   (w_tok[g+1])
            );
        end
    endgenerate

    assign w_full   = (r_count == sist_pkg::CNT_W'(sist_pkg::CAPACITY));
    assign w_is_ins = (r_op == sist_pkg::OP_INSERT);
    assign w_ins_do = w_is_ins && !r_hit && !w_full;
    assign w_reject = w_is_ins && !r_hit && w_full;
    assign w_rem_do = (r_op == sist_pkg::OP_REMOVE) && r_hit;

    assign w_wr.en   = w_commit && (w_ins_do || w_rem_do);
    assign w_wr.idx  = w_ins_do ? r_count[sist_pkg::IDX_W-1:0] : r_slot;
    assign w_wr.data = w_ins_do ? r_key : r_last;

    always_comb begin
        n_count = r_count;
        if (w_ins_do) begin
            n_count = r_count + sist_pkg::CNT_W'(1);
        end else if (w_rem_do) begin
            n_count = r_count - sist_pkg::CNT_W'(1);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (w_tok[sist_pkg::CAPACITY].valid) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_launch    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= w_accept;
            if (w_commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= s_axis_tdata[1:0];
            r_key <= sist_pkg::f_key(s_axis_tdata[33:2]);
        end
        if ((r_state == S_SEARCH) && w_tok[sist_pkg::CAPACITY].valid) begin
            r_hit  <= w_tok[sist_pkg::CAPACITY].hit;
            r_slot <= w_tok[sist_pkg::CAPACITY].slot;
            r_last <= w_tok[sist_pkg::CAPACITY].last;
        end
        if (w_commit) begin
            r_out_data <= {7'b0, w_reject, 7'(n_count), r_hit};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sist_pkg::CNT_W'(sist_pkg::CAPACITY))
        else $error("stored count exceeds capacity");

    a_tok_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[sist_pkg::CAPACITY].valid |-> (r_state == S_SEARCH))
        else $error("search token left the row outside a search");

    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_commit |=> $stable(r_count))
        else $error("count changed without a commit");

    a_reject_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[8]) |-> !r_out_data[0])
        else $error("rejected insert reported a present value");

endmodule
